[rtl/core/drb_pkg.sv]
// Package for the DRAM row-buffer request scheduler.
// Holds payload structs, queue entry layout, register indexes and sizing constants.
// No dependencies.
`default_nettype none
package drb_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int NumRowsDefault    = 512;
  localparam int RowWords          = 256;
  localparam int RowBytes          = 1024;
  localparam int FifoDepth         = 2;

  localparam int RowW  = 9;
  localparam int WordW = 8;

  // Operation codes of an input beat; the spare code acts as a plain tick.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_STORE = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Register indexes of the configuration port.
  localparam logic REG_ROW_DELAY = 1'b0;
  localparam logic REG_COL_DELAY = 1'b1;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_OPEN = 2'd1,
    KIND_SWAP = 2'd2
  } drb_kind_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [18:0]        address;
    logic signed [31:0] store_data;
    logic [4:0]         load_tag;
  } drb_req_t;

  typedef struct packed {
    logic               load_done;
    logic [4:0]         done_tag;
    logic signed [31:0] load_data;
    logic               store_done;
    logic               row_written_back;
    logic               row_opened;
    logic               bad_address;
    logic               rejected;
    logic               queue_empty;
  } drb_rsp_t;

  // One pending request.
  typedef struct packed {
    logic              is_store;
    logic [RowW-1:0]   row;
    logic [WordW-1:0]  word;
    logic [31:0]       payload;
  } drb_entry_t;

  // One classified tick handed from the front to the back.
  typedef struct packed {
    logic       is_req;
    logic       bad;
    drb_entry_t entry;
  } drb_tick_t;

  typedef struct packed {
    logic [5:0] row_delay;
    logic [5:0] col_delay;
  } drb_cfg_t;

  // Handshake between the front and the back.
  typedef struct packed {
    logic      valid;
    drb_tick_t tick;
  } drb_fwd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } drb_bwd_t;

endpackage
`default_nettype wire

[rtl/core/drb_front.sv]
// Front part: takes input beats, checks the address and buffers classified ticks.
// Depends on drb_pkg.
`default_nettype none
module drb_front #(
  parameter int NumRows = drb_pkg::NumRowsDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  drb_pkg::drb_req_t req_i,
  output logic              busy_o,
  output drb_pkg::drb_fwd_t fwd_o,
  input  drb_pkg::drb_bwd_t bwd_i
);

  localparam int PtrW = (drb_pkg::FifoDepth > 1) ? $clog2(drb_pkg::FifoDepth) : 1;
  localparam int CntW = $clog2(drb_pkg::FifoDepth + 1);

  drb_pkg::drb_tick_t fifo_q [drb_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  drb_pkg::drb_tick_t tick;

  // Classify the beat: request kind, alignment and range check.
  always_comb begin
    tick.is_req = (req_i.operation == drb_pkg::OP_LOAD) ||
                  (req_i.operation == drb_pkg::OP_STORE);
    tick.bad    = (req_i.address[1:0] != 2'b00) ||
                  (int'(req_i.address[18:10]) >= NumRows);
    tick.entry.is_store = (req_i.operation == drb_pkg::OP_STORE);
    tick.entry.row      = req_i.address[18:10];
    tick.entry.word     = req_i.address[9:2];
    tick.entry.payload  = (req_i.operation == drb_pkg::OP_STORE) ?
                          req_i.store_data : {27'd0, req_i.load_tag};
  end

  assign busy_o = bwd_i.clearing || (cnt_q == CntW'(drb_pkg::FifoDepth));
  assign push   = start_i && !busy_o;

  assign fwd_o.valid = (cnt_q != '0);
  assign fwd_o.tick  = fifo_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(drb_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (bwd_i.pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(drb_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(bwd_i.pop);
    end
  end

  // Buffer storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= tick;
    end
  end

endmodule
`default_nettype wire

[rtl/core/drb_back.sv]
// Back part: request queue, head timing, row-hit grouping and the DRAM store.
// Depends on drb_pkg.
`default_nettype none
module drb_back #(
  parameter int QueueDepth = drb_pkg::QueueDepthDefault,
  parameter int NumRows    = drb_pkg::NumRowsDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  drb_pkg::drb_cfg_t cfg_i,
  input  drb_pkg::drb_fwd_t fwd_i,
  output drb_pkg::drb_bwd_t bwd_o,
  output logic              result_valid_o,
  output drb_pkg::drb_rsp_t rsp_o,
  output logic [$clog2(QueueDepth+1)-1:0] count_o
);

  localparam int MemDepth = NumRows * drb_pkg::RowWords;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int CntW     = $clog2(QueueDepth + 1);
  localparam int IdxW     = $clog2(QueueDepth);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HEAD   = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_SORT   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;
  drb_pkg::drb_entry_t q_q [QueueDepth];
  drb_pkg::drb_entry_t q_d [QueueDepth];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       prog_q, prog_d, lat_q, lat_d;
  drb_pkg::drb_kind_e kind_q, kind_d;
  logic [5:0]       rdel_q, rdel_d;
  logic [drb_pkg::RowW-1:0] orow_q, orow_d;
  logic             ovalid_q, ovalid_d;
  logic [IdxW-1:0]  pass_q, pass_d;
  drb_pkg::drb_tick_t tick_q;
  drb_pkg::drb_rsp_t  flags_q, flags_d;
  logic             clr_q;
  logic [MemAw-1:0] clr_addr_q;
  logic [31:0]      mem_q [MemDepth];
  logic [31:0]      mem_rdata_q;
  logic             mem_we, mem_re, pop;
  logic [MemAw-1:0] head_idx, mem_widx;
  logic [5:0]       rd_eff, cd_eff;
  logic             key_l, key_r;

  assign head_idx = MemAw'({q_q[0].row, q_q[0].word});
  assign rd_eff   = (cfg_i.row_delay < 6'd2) ? 6'd2 : cfg_i.row_delay;
  assign cd_eff   = (cfg_i.col_delay == 6'd0) ? 6'd1 : cfg_i.col_delay;
  assign pop      = (state_q == S_IDLE) && !clr_q && fwd_i.valid;

  assign bwd_o.pop      = pop;
  assign bwd_o.clearing = clr_q;
  assign count_o        = cnt_q;

  // Sequencer: head step, append, grouping passes, result.
  always_comb begin
    state_d  = state_q;
    q_d      = q_q;
    cnt_d    = cnt_q;
    prog_d   = prog_q;
    lat_d    = lat_q;
    kind_d   = kind_q;
    rdel_d   = rdel_q;
    orow_d   = orow_q;
    ovalid_d = ovalid_q;
    pass_d   = pass_q;
    flags_d  = flags_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    key_l    = 1'b0;
    key_r    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          flags_d = '0;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        state_d = S_APPEND;
        if (cnt_q != '0) begin
          priority if (prog_q == 8'd0) begin
            if (ovalid_q && (orow_q == q_q[0].row)) begin
              kind_d = drb_pkg::KIND_HIT;
              lat_d  = {2'b00, cd_eff};
            end else if (ovalid_q) begin
              kind_d = drb_pkg::KIND_SWAP;
              lat_d  = {2'b00, cd_eff} + {1'b0, rd_eff, 1'b0};
            end else begin
              kind_d = drb_pkg::KIND_OPEN;
              lat_d  = {2'b00, cd_eff} + {2'b00, rd_eff};
            end
            rdel_d = rd_eff;
            prog_d = 8'd1;
          end else if ((kind_q != drb_pkg::KIND_HIT) &&
                       (prog_q == {2'b00, rdel_q} - 8'd1)) begin
            if (kind_q == drb_pkg::KIND_SWAP) begin
              flags_d.row_written_back = 1'b1;
            end else begin
              flags_d.row_opened = 1'b1;
              orow_d   = q_q[0].row;
              ovalid_d = 1'b1;
            end
            prog_d = prog_q + 8'd1;
          end else if ((kind_q == drb_pkg::KIND_SWAP) &&
                       (prog_q == {1'b0, rdel_q, 1'b0} - 8'd1)) begin
            flags_d.row_opened = 1'b1;
            orow_d   = q_q[0].row;
            ovalid_d = 1'b1;
            prog_d   = prog_q + 8'd1;
          end else if ({1'b0, prog_q} + 9'd1 >= {1'b0, lat_q}) begin
            // Column access at the open row, then retire the head.
            if (q_q[0].is_store) begin
              mem_we = 1'b1;
              flags_d.store_done = 1'b1;
            end else begin
              mem_re = 1'b1;
              flags_d.load_done = 1'b1;
              flags_d.done_tag  = q_q[0].payload[4:0];
            end
            for (int i = 0; i < QueueDepth - 1; i++) begin
              q_d[i] = q_q[i+1];
            end
            cnt_d  = cnt_q - 1'b1;
            prog_d = 8'd0;
          end else begin
            prog_d = prog_q + 8'd1;
          end
        end
      end
      S_APPEND: begin
        pass_d  = '0;
        state_d = S_SORT;
        if (tick_q.is_req) begin
          if (tick_q.bad) begin
            flags_d.bad_address = 1'b1;
          end else if (cnt_q == CntW'(QueueDepth)) begin
            flags_d.rejected = 1'b1;
          end else begin
            q_d[cnt_q[IdxW-1:0]] = tick_q.entry;
            if (cnt_q == '0) begin
              prog_d = 8'd0;
            end
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_SORT: begin
        // One odd-even transposition pass: head-row entries move forward, stable.
        for (int i = 1; i < QueueDepth - 1; i++) begin
          key_l = (q_q[i].row != q_q[0].row);
          key_r = (q_q[i+1].row != q_q[0].row);
          if ((i[0] == pass_q[0]) && ((i + 1) < int'(cnt_q)) && key_l && !key_r) begin
            q_d[i]   = q_q[i+1];
            q_d[i+1] = q_q[i];
          end
        end
        pass_d = pass_q + 1'b1;
        if (pass_q == IdxW'(QueueDepth - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result beat.
  always_comb begin
    rsp_o             = flags_q;
    rsp_o.load_data   = flags_q.load_done ? mem_rdata_q : 32'd0;
    rsp_o.queue_empty = (cnt_q == '0);
  end
  assign result_valid_o = (state_q == S_EMIT);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      prog_q     <= '0;
      lat_q      <= '0;
      kind_q     <= drb_pkg::KIND_HIT;
      rdel_q     <= '0;
      orow_q     <= '0;
      ovalid_q   <= 1'b0;
      pass_q     <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      prog_q   <= prog_d;
      lat_q    <= lat_d;
      kind_q   <= kind_d;
      rdel_q   <= rdel_d;
      orow_q   <= orow_d;
      ovalid_q <= ovalid_d;
      pass_q   <= pass_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == MemAw'(MemDepth - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    q_q     <= q_d;
    flags_q <= flags_d;
    if (pop) begin
      tick_q <= fwd_i.tick;
    end
  end

  // DRAM store; the open row buffer is the array row itself.
  assign mem_widx = clr_q ? clr_addr_q : head_idx;
  always_ff @(posedge clk_i) begin
    if (clr_q || mem_we) begin
      mem_q[mem_widx] <= clr_q ? 32'd0 : q_q[0].payload;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[head_idx];
    end
  end

endmodule
`default_nettype wire

[rtl/core/dram_row_buffer_request_scheduler_core.sv]
// Top level of the DRAM row-buffer request scheduler: APB registers, front, back.
// Depends on drb_pkg, drb_front and drb_back.
//
// Usage: each input beat is one DRAM tick, taken when start is high and busy is
// low; it may carry a load or store request in req_i. Every tick yields exactly
// one result beat on rsp_o, marked by result_valid_o for one cycle; the receiver
// cannot stall. Each tick goes through these steps in order: it is taken from
// the input buffer, the head step runs, the tick is appended, QUEUE_DEPTH
// grouping passes run over the request queue, and the result is emitted. The
// back takes no new tick before it has emitted the last result.
// Two ticks may wait in the front buffer while the back works.
// After reset the DRAM store is cleared one word a cycle, with busy high;
// configuration writes work throughout.
// Delay registers sit at byte address 0 (row delay) and 4 (column delay). The
// user must write them only while no tick is in flight (not enforced).
`default_nettype none
module dram_row_buffer_request_scheduler_core #(
  parameter int QUEUE_DEPTH = drb_pkg::QueueDepthDefault,
  parameter int NUM_ROWS    = drb_pkg::NumRowsDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  drb_pkg::drb_req_t req_i,
  output logic              result_valid_o,
  output drb_pkg::drb_rsp_t rsp_o,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [2:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  drb_pkg::drb_cfg_t cfg_q;
  drb_pkg::drb_fwd_t fwd;
  drb_pkg::drb_bwd_t bwd;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_delay <= 6'd10;
      cfg_q.col_delay <= 6'd2;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == drb_pkg::REG_ROW_DELAY) begin
        cfg_q.row_delay <= pwdata[5:0];
      end else begin
        cfg_q.col_delay <= pwdata[5:0];
      end
    end
  end
  assign prdata = (paddr[2] == drb_pkg::REG_COL_DELAY) ? {26'd0, cfg_q.col_delay} :
                                                         {26'd0, cfg_q.row_delay};

  drb_front #(
    .NumRows(NUM_ROWS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .req_i (req_i),
    .busy_o(busy),
    .fwd_o (fwd),
    .bwd_i (bwd)
  );

  drb_back #(
    .QueueDepth(QUEUE_DEPTH),
    .NumRows   (NUM_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fwd_i         (fwd),
    .bwd_o         (bwd),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o),
    .count_o       (count)
  );

`ifndef SYNTH
  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count) <= QUEUE_DEPTH) else $error("request queue overflow");

  // A rejection happens only with a full queue.
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.rejected) |-> (int'(count) == QUEUE_DEPTH))
    else $error("rejection without a full queue");

  // No result while the store is being cleared.
  a_no_result_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bwd.clearing |-> !result_valid_o) else $error("result during clearing");

  // A tick never both loads and stores.
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(rsp_o.load_done && rsp_o.store_done))
    else $error("load and store in one tick");
`endif

endmodule
`default_nettype wire

[bench/dram_row_buffer_request_scheduler_core_tb.sv]
// Self-checking testbench for the DRAM row-buffer request scheduler core.
// Depends on drb_pkg and dram_row_buffer_request_scheduler_core.
// A tick-level predictor of the queue, row buffer and DRAM store checks every result beat.
`timescale 1ns / 1ps
module dram_row_buffer_request_scheduler_core_tb;

  localparam int QDepth    = 16;
  localparam int NRows     = 512;
  localparam int SettleCyc = QDepth + 12;
  localparam int CycLimit  = 1000000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  drb_pkg::drb_req_t req_i;
  logic              result_valid_o;
  drb_pkg::drb_rsp_t rsp_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  dram_row_buffer_request_scheduler_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .result_valid_o(result_valid_o), .rsp_o(rsp_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: pending requests, head timing, open row and memories.
  typedef struct {
    logic        is_store;
    logic [18:0] addr;
    logic [31:0] payload;
  } pend_t;

  pend_t              pend_q[QDepth];
  int                 pend_n;
  int                 head_prog;
  int                 head_lat;
  int                 head_rd;
  drb_pkg::drb_kind_e head_kind;
  logic [8:0]         cur_row;
  logic               cur_row_ok;
  logic [31:0]        row_buf[drb_pkg::RowWords];
  logic [31:0]        dram_mem[int];
  logic [5:0]         cfg_row_delay;
  logic [5:0]         cfg_col_delay;

  drb_pkg::drb_rsp_t  pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  int          beats_sent;
  int          beats_checked = 0;
  int          loads_seen = 0;
  int          stores_seen = 0;
  int          rejects_seen = 0;
  int          bad_seen = 0;
  logic        idling_on;
  logic [8:0]  hot_rows[4];

  // Clock and cycle limit.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[dram_row_buffer_request_scheduler_core] ERROR");
      $finish;
    end
  end

  // Stable move of the head's row group right behind the head.
  function automatic void group_head_row();
    pend_t tmp[QDepth];
    int k;
    if (pend_n < 2) return;
    k = 1;
    tmp[0] = pend_q[0];
    for (int i = 1; i < pend_n; i++)
      if (pend_q[i].addr[18:10] == pend_q[0].addr[18:10]) begin
        tmp[k] = pend_q[i];
        k++;
      end
    for (int i = 1; i < pend_n; i++)
      if (pend_q[i].addr[18:10] != pend_q[0].addr[18:10]) begin
        tmp[k] = pend_q[i];
        k++;
      end
    for (int i = 0; i < pend_n; i++) pend_q[i] = tmp[i];
  endfunction

  function automatic void copy_back();
    for (int w = 0; w < drb_pkg::RowWords; w++) dram_mem[{cur_row, w[7:0]}] = row_buf[w];
  endfunction

  function automatic void activate(logic [8:0] r);
    for (int w = 0; w < drb_pkg::RowWords; w++)
      row_buf[w] = dram_mem.exists({r, w[7:0]}) ? dram_mem[{r, w[7:0]}] : 32'd0;
    cur_row    = r;
    cur_row_ok = 1'b1;
  endfunction

  // Advances the predictor by one DRAM tick and returns the expected result.
  function automatic drb_pkg::drb_rsp_t dram_tick(drb_pkg::drb_req_t t);
    drb_pkg::drb_rsp_t o;
    logic [8:0] r;
    logic [7:0] w;
    int         rd;
    int         cd;
    o = '0;
    if (pend_n > 0) begin
      r = pend_q[0].addr[18:10];
      if (head_prog == 0) begin
        rd = (cfg_row_delay < 2) ? 2 : int'(cfg_row_delay);
        cd = (cfg_col_delay < 1) ? 1 : int'(cfg_col_delay);
        if (cur_row_ok && cur_row == r) head_kind = drb_pkg::KIND_HIT;
        else if (cur_row_ok) head_kind = drb_pkg::KIND_SWAP;
        else head_kind = drb_pkg::KIND_OPEN;
        head_rd   = rd;
        head_lat  = cd + int'(head_kind) * rd;
        head_prog = 1;
      end else if (head_kind != drb_pkg::KIND_HIT && head_prog == head_rd - 1) begin
        if (head_kind == drb_pkg::KIND_SWAP) begin
          copy_back();
          o.row_written_back = 1'b1;
        end else begin
          activate(r);
          o.row_opened = 1'b1;
        end
        head_prog++;
      end else if (head_kind == drb_pkg::KIND_SWAP && head_prog == 2 * head_rd - 1) begin
        activate(r);
        o.row_opened = 1'b1;
        head_prog++;
      end else if (head_prog + 1 >= head_lat) begin
        w = pend_q[0].addr[9:2];
        if (pend_q[0].is_store) begin
          row_buf[w]   = pend_q[0].payload;
          o.store_done = 1'b1;
        end else begin
          o.load_done = 1'b1;
          o.done_tag  = pend_q[0].payload[4:0];
          o.load_data = row_buf[w];
        end
        for (int i = 0; i + 1 < pend_n; i++) pend_q[i] = pend_q[i+1];
        pend_n--;
        head_prog = 0;
        group_head_row();
      end else begin
        head_prog++;
      end
    end
    if (t.operation == drb_pkg::OP_LOAD || t.operation == drb_pkg::OP_STORE) begin
      if (t.address[1:0] != 2'b00 || int'(t.address[18:10]) >= NRows) begin
        o.bad_address = 1'b1;
      end else if (pend_n >= QDepth) begin
        o.rejected = 1'b1;
      end else begin
        pend_q[pend_n].is_store = (t.operation == drb_pkg::OP_STORE);
        pend_q[pend_n].addr     = t.address;
        pend_q[pend_n].payload  = (t.operation == drb_pkg::OP_STORE) ? t.store_data
                                                                     : {27'd0, t.load_tag};
        if (pend_n == 0) head_prog = 0;
        pend_n++;
        group_head_row();
      end
    end
    o.queue_empty = (pend_n == 0);
    return o;
  endfunction

  // Sends one tick beat, with an occasional random gap before it.
  task automatic send_tick(drb_pkg::drb_req_t t);
    drb_pkg::drb_rsp_t exp_rsp;
    if (idling_on && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= t;
    do @(posedge clk_i); while (busy);
    exp_rsp = dram_tick(t);
    pending_results = {pending_results, exp_rsp};
    beats_sent++;
    @(negedge clk_i);
  endtask

  function automatic drb_pkg::drb_req_t make_req(logic [1:0] op, logic [18:0] a,
                                                 logic [31:0] d, logic [4:0] tg);
    drb_pkg::drb_req_t t;
    t.operation  = op;
    t.address    = a;
    t.store_data = d;
    t.load_tag   = tg;
    return t;
  endfunction

  // Waits until every result has come back and the block has gone quiet.
  task automatic drain();
    start <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [5:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {26'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == drb_pkg::REG_ROW_DELAY) cfg_row_delay = val;
    else cfg_col_delay = val;
  endtask

  task automatic set_delays(logic [5:0] rd, logic [5:0] cd);
    drain();
    write_reg(drb_pkg::REG_ROW_DELAY, rd);
    write_reg(drb_pkg::REG_COL_DELAY, cd);
  endtask

  // Random request address, mostly in a few hot rows so that row hits are common.
  function automatic logic [18:0] pick_addr();
    logic [18:0] a;
    a[18:10] = ($urandom_range(0, 99) < 75) ? hot_rows[$urandom_range(0, 3)]
                                             : 9'($urandom);
    a[9:2]   = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    a[1:0]   = ($urandom_range(0, 99) < 5) ? 2'($urandom_range(1, 3)) : 2'b00;
    return a;
  endfunction

  function automatic drb_pkg::drb_req_t random_req();
    int          p;
    logic [1:0]  op;
    p  = $urandom_range(0, 99);
    op = (p < 35) ? drb_pkg::OP_TICK : (p < 62) ? drb_pkg::OP_LOAD :
         (p < 92) ? drb_pkg::OP_STORE : drb_pkg::OP_SPARE;
    return make_req(op, pick_addr(), $urandom, 5'($urandom));
  endfunction

  // Field extremes, the unused operation code, misalignment and a plain tick.
  task automatic test_field_extremes();
    send_tick(make_req(drb_pkg::OP_STORE, 19'h7FFFC, 32'h7FFFFFFF, 5'd0));
    send_tick(make_req(drb_pkg::OP_STORE, 19'h00000, 32'h80000000, 5'd31));
    send_tick(make_req(drb_pkg::OP_LOAD, 19'h7FFFC, 32'hFFFFFFFF, 5'd31));
    send_tick(make_req(drb_pkg::OP_LOAD, 19'h00000, 32'h0, 5'd0));
    send_tick(make_req(drb_pkg::OP_SPARE, 19'h7FFFF, 32'hFFFFFFFF, 5'd31));
    send_tick(make_req(drb_pkg::OP_LOAD, 19'h00401, 32'h0, 5'd7));
    send_tick(make_req(drb_pkg::OP_STORE, 19'h7FFFE, 32'h12345678, 5'd0));
    send_tick(make_req(drb_pkg::OP_TICK, 19'h7FFFF, 32'hFFFFFFFF, 5'd31));
    repeat (60) send_tick(make_req(drb_pkg::OP_TICK, 19'd0, 32'd0, 5'd0));
  endtask

  // Overfills the queue while the head is still running.
  task automatic test_queue_full();
    for (int i = 0; i < QDepth + 2; i++)
      send_tick(make_req(drb_pkg::OP_LOAD, {9'(i % 3 + 5), 8'(i), 2'b00}, 32'd0, 5'(i)));
  endtask

  // Row hit with equal row and column delays, after the row has been opened.
  task automatic test_equal_delays();
    set_delays(6'd5, 6'd5);
    send_tick(make_req(drb_pkg::OP_STORE, 19'h01010, 32'hA5A5A5A5, 5'd0));
    send_tick(make_req(drb_pkg::OP_LOAD, 19'h01010, 32'd0, 5'd9));
    repeat (40) send_tick(make_req(drb_pkg::OP_TICK, 19'd0, 32'd0, 5'd0));
  endtask

  task automatic test_random_phase(logic [5:0] rd, logic [5:0] cd, int n, logic quiet);
    set_delays(rd, cd);
    for (int i = 0; i < 4; i++) hot_rows[i] = 9'($urandom);
    idling_on = !quiet;
    for (int i = 0; i < n; i++) send_tick(random_req());
    idling_on = 1'b1;
  endtask

  // Checks each result beat against the oldest prediction.
  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    drb_pkg::drb_rsp_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, rsp_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("load_done", e.load_done, rsp_o.load_done);
        check_field("done_tag", e.done_tag, rsp_o.done_tag);
        check_field("load_data", e.load_data, rsp_o.load_data);
        check_field("store_done", e.store_done, rsp_o.store_done);
        check_field("row_written_back", e.row_written_back, rsp_o.row_written_back);
        check_field("row_opened", e.row_opened, rsp_o.row_opened);
        check_field("bad_address", e.bad_address, rsp_o.bad_address);
        check_field("rejected", e.rejected, rsp_o.rejected);
        check_field("queue_empty", e.queue_empty, rsp_o.queue_empty);
        beats_checked++;
        loads_seen   += e.load_done;
        stores_seen  += e.store_done;
        rejects_seen += e.rejected;
        bad_seen     += e.bad_address;
      end
    end
  end

  initial begin
    start   = 1'b0;
    req_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    beats_sent = 0;
    idling_on = 1'b1;
    pend_n = 0;
    head_prog = 0;
    head_lat = 0;
    head_rd = 0;
    head_kind = drb_pkg::KIND_HIT;
    cur_row = '0;
    cur_row_ok = 1'b0;
    cfg_row_delay = 6'd10;
    cfg_col_delay = 6'd2;
    for (int w = 0; w < drb_pkg::RowWords; w++) row_buf[w] = '0;
    for (int i = 0; i < 4; i++) hot_rows[i] = 9'($urandom);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_field_extremes();
    test_queue_full();
    test_equal_delays();
    test_random_phase(6'd10, 6'd2, 220, 1'b0);
    test_random_phase(6'd2, 6'd1, 260, 1'b1);
    test_random_phase(6'd0, 6'd0, 180, 1'b0);
    test_random_phase(6'd63, 6'd63, 120, 1'b0);
    test_random_phase(6'd2, 6'd63, 120, 1'b0);
    test_random_phase(6'd3, 6'd3, 200, 1'b0);
    test_random_phase(6'd1, 6'd17, 180, 1'b0);
    test_random_phase(6'd7, 6'd4, 200, 1'b0);

    drain();
    $display("%0d tick beats checked: %0d loads, %0d stores, %0d rejected, %0d bad addresses",
             beats_checked, loads_seen, stores_seen, rejects_seen, bad_seen);
    $display("delay settings swept from the clamped minimum to 63, with gaps and a full queue");
    if (errors == 0 && beats_checked == beats_sent)
      $display("[dram_row_buffer_request_scheduler_core] OK");
    else
      $display("[dram_row_buffer_request_scheduler_core] ERROR");
    $finish;
  end

endmodule
